@@ rtl/pll_ds_pkg.sv @@
// Package for the PLL divider search: widths, frequency limits, status codes
// and the high/low count encoder. No dependencies.
`timescale 1ns / 1ps
package pll_ds_pkg;
   localparam int HZ_W   = 30;
   localparam int TOL_W  = 27;
   localparam int DIV_W  = 7;
   localparam int DEN_W  = 2 * DIV_W;
   localparam int NUM_W  = HZ_W + DIV_W;
   localparam int MA_W   = 48;
   localparam int PROD_W = MA_W + DEN_W;
   localparam int ERR_W  = 48;
   localparam int WORD_W = 16;
   localparam int IDX_W  = 2;

   localparam int DEF_MAX_DIV_D  = 80;
   localparam int DEF_MAX_DIV_MO = 64;
   localparam int DEF_MIN_DIV_M  = 5;

   localparam logic [HZ_W-1:0]  RST_INPUT_CLOCK = 30'd100000000;
   localparam logic [HZ_W-1:0]  RST_OUTPUT_MAX  = 30'd750000000;
   localparam logic [TOL_W-1:0] RST_TOLERANCE   = 27'd1000;

   localparam logic [MA_W-1:0] CLK_MIN_HZ = 48'd10000000;
   localparam logic [MA_W-1:0] CLK_MAX_HZ = 48'd800000000;
   localparam logic [MA_W-1:0] REQ_MAX_HZ = 48'd750000000;
   localparam logic [MA_W-1:0] PFD_MIN_HZ = 48'd10000000;
   localparam logic [MA_W-1:0] PFD_MAX_HZ = 48'd300000000;
   localparam logic [MA_W-1:0] VCO_MIN_HZ = 48'd600000000;
   localparam logic [MA_W-1:0] VCO_MAX_HZ = 48'd1440000000;

   localparam logic [IDX_W-1:0] REG_INPUT_CLOCK = 2'd0;
   localparam logic [IDX_W-1:0] REG_OUTPUT_MAX  = 2'd1;
   localparam logic [IDX_W-1:0] REG_TOLERANCE   = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CLK_RANGE = 3'd1;
   localparam logic [2:0] ST_REQ_RANGE = 3'd2;
   localparam logic [2:0] ST_TOL_ZERO  = 3'd3;
   localparam logic [2:0] ST_NONE      = 3'd4;

   localparam logic [WORD_W-1:0] WORD_D_ONE   = 16'h3001;
   localparam logic [WORD_W-1:0] WORD_O_ONE   = 16'h1001;
   localparam logic [WORD_W-1:0] WORD_EXT_ONE = 16'h00C0;
   localparam logic [WORD_W-1:0] WORD_BASE    = 16'h1000;

   // high count in [12:6], low count in [5:0]; zero for n <= 1
   function automatic logic [WORD_W-1:0] hl_code(input logic [DIV_W:0] n);
      logic [DIV_W:0] lo;
      logic [DIV_W:0] hi;
      logic [WORD_W-1:0] code;
      lo = n >> 1;
      hi = n - lo;
      code = ({8'd0, hi} << 6) | {8'd0, lo};
      if (n <= 1) begin
         code = '0;
      end
      return code;
   endfunction
endpackage

@@ rtl/pll_divider_search.sv @@
// Top level of the PLL divider search: sequencer, shared multiplier and
// serial divider. Depends on pll_ds_pkg.
`timescale 1ns / 1ps
// Usage:
//  - Configure input_clock_hz (0), output_max_hz (1), tolerance_hz (2) through
//    csr_wr_en/csr_index/csr_wr_data while the block is idle. Other indexes
//    are ignored. Reset loads 100 MHz, 750 MHz and 1000 Hz.
//  - Pulse start with req_requested_hz while busy is low. The word is taken
//    at that edge and busy rises.
//  - One result word comes out per request: rsp_valid is high for exactly one
//    cycle with all rsp_ fields; the receiver cannot stall it.
//  - Range errors (clock, request, zero tolerance) skip the search entirely.
//  - Otherwise the search walks D up, M down, O down. Each D, each M tried
//    under a passing D and each O candidate is checked in its own states,
//    all through the single 48x14 multiplier that every search compare goes
//    through. With default limits at most 80 D values, 4800 D/M pairs and
//    307200 O candidates are tried; a typical clock needs far less search
//    since most D and M values fail the PFD/VCO window.
//  - A hit is then finished by three 37-step divisions for output, VCO and
//    PFD frequency.
//  - Reset returns to idle and drops any search in flight.
module pll_divider_search #(
   parameter int MAX_DIV_D  = pll_ds_pkg::DEF_MAX_DIV_D,
   parameter int MAX_DIV_MO = pll_ds_pkg::DEF_MAX_DIV_MO,
   parameter int MIN_DIV_M  = pll_ds_pkg::DEF_MIN_DIV_M
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [pll_ds_pkg::HZ_W-1:0] req_requested_hz,
   input  logic csr_wr_en,
   input  logic [pll_ds_pkg::IDX_W-1:0] csr_index,
   input  logic [pll_ds_pkg::HZ_W-1:0] csr_wr_data,
   output logic rsp_valid,
   output logic [2:0] rsp_status,
   output logic [pll_ds_pkg::DIV_W-1:0] rsp_div_d,
   output logic [pll_ds_pkg::DIV_W-1:0] rsp_div_m,
   output logic [pll_ds_pkg::DIV_W-1:0] rsp_div_o,
   output logic [pll_ds_pkg::WORD_W-1:0] rsp_word_divclk,
   output logic [pll_ds_pkg::WORD_W-1:0] rsp_word_feedback,
   output logic [pll_ds_pkg::WORD_W-1:0] rsp_word_out0,
   output logic [pll_ds_pkg::WORD_W-1:0] rsp_word_out0_ext,
   output logic [pll_ds_pkg::WORD_W-1:0] rsp_word_out1,
   output logic [30:0] rsp_achieved_hz,
   output logic [30:0] rsp_vco_hz,
   output logic [28:0] rsp_pfd_hz
);
   localparam int DW = pll_ds_pkg::DIV_W;
   localparam int NW = pll_ds_pkg::NUM_W;
   localparam int AW = pll_ds_pkg::MA_W;
   localparam int PW = pll_ds_pkg::PROD_W;
   localparam int EW = pll_ds_pkg::ERR_W;
   localparam int QW = pll_ds_pkg::DEN_W;
   localparam int HW = pll_ds_pkg::HZ_W;
   localparam logic [DW-1:0] D_MAX = DW'(MAX_DIV_D);
   localparam logic [DW-1:0] MO_MAX = DW'(MAX_DIV_MO);
   localparam logic [DW-1:0] M_MIN = DW'(MIN_DIV_M);
   localparam logic M_EMPTY = (MIN_DIV_M > MAX_DIV_MO);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_D_LO = 5'd1;
   localparam logic [4:0] S_D_HI = 5'd2;
   localparam logic [4:0] S_D_CHK = 5'd3;
   localparam logic [4:0] S_M_NUM = 5'd4;
   localparam logic [4:0] S_M_LO = 5'd5;
   localparam logic [4:0] S_M_HI = 5'd6;
   localparam logic [4:0] S_M_CHK = 5'd7;
   localparam logic [4:0] S_O_DEN = 5'd8;
   localparam logic [4:0] S_O_TGT = 5'd9;
   localparam logic [4:0] S_O_TOL = 5'd10;
   localparam logic [4:0] S_O_MAX = 5'd11;
   localparam logic [4:0] S_O_BA = 5'd12;
   localparam logic [4:0] S_O_BB = 5'd13;
   localparam logic [4:0] S_O_CMP = 5'd14;
   localparam logic [4:0] S_F_NUM = 5'd15;
   localparam logic [4:0] S_F_LOAD = 5'd16;
   localparam logic [4:0] S_DIV = 5'd17;
   localparam logic [4:0] S_DONE = 5'd18;

   // configuration
   logic [HW-1:0] fin_ff, omax_ff;
   logic [pll_ds_pkg::TOL_W-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff  <= pll_ds_pkg::RST_INPUT_CLOCK;
         omax_ff <= pll_ds_pkg::RST_OUTPUT_MAX;
         tol_ff  <= pll_ds_pkg::RST_TOLERANCE;
      end else if (csr_wr_en) begin
         case (csr_index)
            pll_ds_pkg::REG_INPUT_CLOCK: fin_ff <= csr_wr_data;
            pll_ds_pkg::REG_OUTPUT_MAX: omax_ff <= csr_wr_data;
            pll_ds_pkg::REG_TOLERANCE: tol_ff <= csr_wr_data[pll_ds_pkg::TOL_W-1:0];
            default: ;
         endcase
      end
   end

   logic [4:0] state_ff, state_in;
   logic [HW-1:0] req_ff, req_in;
   logic [DW-1:0] d_ff, d_in, m_ff, m_in, o_ff, o_in;
   logic [DW-1:0] bd_ff, bd_in, bm_ff, bm_in, bo_ff, bo_in;
   logic [QW-1:0] bden_ff, bden_in, den_ff, den_in;
   logic [EW-1:0] berr_ff, berr_in, err_ff, err_in;
   logic found_ff, found_in, flag_ff, flag_in;
   logic [NW-1:0] num_ff, num_in;
   logic [PW-1:0] tmp_ff, tmp_in, prod_ff;
   logic [2:0] status_ff, status_in;
   logic valid_ff, valid_in;
   logic [AW-1:0] mul_a;
   logic [QW-1:0] mul_b;
   logic adv_o, adv_m, adv_d;
   // divider
   logic [NW-1:0] quo_ff, quo_in;
   logic [QW-1:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] sel_ff, sel_in;
   logic [30:0] ach_ff, ach_in, vco_ff, vco_in;
   logic [28:0] pfd_ff, pfd_in;
   logic [QW:0] rem_sh;
   logic rem_ge;
   logic [PW-1:0] num_w, err_abs;

   assign rem_sh  = {rem_ff, quo_ff[NW-1]};
   assign rem_ge  = rem_sh >= {1'b0, dvs_ff};
   assign num_w   = PW'(num_ff);
   assign err_abs = (num_w >= prod_ff) ? num_w - prod_ff : prod_ff - num_w;

   // shared multiplier, product registered
   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_D_LO: begin mul_a = pll_ds_pkg::PFD_MIN_HZ; mul_b = QW'(d_ff); end
         S_D_HI: begin mul_a = pll_ds_pkg::PFD_MAX_HZ; mul_b = QW'(d_ff); end
         S_M_NUM: begin mul_a = AW'(fin_ff); mul_b = QW'(m_ff); end
         S_M_LO: begin mul_a = pll_ds_pkg::VCO_MIN_HZ; mul_b = QW'(d_ff); end
         S_M_HI: begin mul_a = pll_ds_pkg::VCO_MAX_HZ; mul_b = QW'(d_ff); end
         S_O_DEN: begin mul_a = AW'(d_ff); mul_b = QW'(o_ff); end
         S_O_TGT: begin mul_a = AW'(req_ff); mul_b = prod_ff[QW-1:0]; end
         S_O_TOL: begin mul_a = AW'(tol_ff); mul_b = den_ff; end
         S_O_MAX: begin mul_a = AW'(omax_ff); mul_b = den_ff; end
         S_O_BA: begin mul_a = err_ff; mul_b = bden_ff; end
         S_O_BB: begin mul_a = berr_ff; mul_b = den_ff; end
         S_F_NUM: begin mul_a = AW'(fin_ff); mul_b = QW'(bm_ff); end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      d_in = d_ff; m_in = m_ff; o_in = o_ff;
      bd_in = bd_ff; bm_in = bm_ff; bo_in = bo_ff;
      bden_in = bden_ff; berr_in = berr_ff; found_in = found_ff;
      den_in = den_ff; err_in = err_ff; flag_in = flag_ff;
      num_in = num_ff; tmp_in = tmp_ff;
      status_in = status_ff;
      valid_in = 1'b0;
      quo_in = quo_ff; rem_in = rem_ff; dvs_in = dvs_ff;
      cnt_in = cnt_ff; sel_in = sel_ff;
      ach_in = ach_ff; vco_in = vco_ff; pfd_in = pfd_ff;
      adv_o = 1'b0; adv_m = 1'b0; adv_d = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_requested_hz;
               if (AW'(fin_ff) < pll_ds_pkg::CLK_MIN_HZ ||
                   AW'(fin_ff) > pll_ds_pkg::CLK_MAX_HZ) begin
                  status_in = pll_ds_pkg::ST_CLK_RANGE;
                  state_in = S_DONE;
               end else if (req_requested_hz == '0 ||
                            AW'(req_requested_hz) > pll_ds_pkg::REQ_MAX_HZ) begin
                  status_in = pll_ds_pkg::ST_REQ_RANGE;
                  state_in = S_DONE;
               end else if (tol_ff == '0) begin
                  status_in = pll_ds_pkg::ST_TOL_ZERO;
                  state_in = S_DONE;
               end else begin
                  status_in = pll_ds_pkg::ST_OK;
                  bd_in = '0; bm_in = '0; bo_in = '0;
                  berr_in = '0; bden_in = '0; found_in = 1'b0;
                  d_in = DW'(1);
                  state_in = S_D_LO;
               end
            end
         end
         S_D_LO: state_in = S_D_HI;
         S_D_HI: begin
            flag_in = PW'(fin_ff) < prod_ff;
            state_in = S_D_CHK;
         end
         S_D_CHK: begin
            if (flag_ff || PW'(fin_ff) > prod_ff || M_EMPTY) begin
               adv_d = 1'b1;
            end else begin
               m_in = MO_MAX;
               state_in = S_M_NUM;
            end
         end
         S_M_NUM: state_in = S_M_LO;
         S_M_LO: begin
            num_in = prod_ff[NW-1:0];
            state_in = S_M_HI;
         end
         S_M_HI: begin
            flag_in = num_w < prod_ff;
            state_in = S_M_CHK;
         end
         S_M_CHK: begin
            if (flag_ff || num_w > prod_ff) begin
               adv_m = 1'b1;
            end else begin
               o_in = MO_MAX;
               state_in = S_O_DEN;
            end
         end
         S_O_DEN: state_in = S_O_TGT;
         S_O_TGT: begin
            den_in = prod_ff[QW-1:0];
            state_in = S_O_TOL;
         end
         S_O_TOL: begin
            err_in = err_abs[EW-1:0];
            state_in = S_O_MAX;
         end
         S_O_MAX: begin
            flag_in = PW'(err_ff) > prod_ff;
            state_in = S_O_BA;
         end
         S_O_BA: begin
            if (flag_ff || num_w > prod_ff) begin
               adv_o = 1'b1;
            end else if (!found_ff) begin
               found_in = 1'b1;
               bd_in = d_ff; bm_in = m_ff; bo_in = o_ff;
               berr_in = err_ff; bden_in = den_ff;
               adv_o = 1'b1;
            end else begin
               state_in = S_O_BB;
            end
         end
         S_O_BB: begin
            tmp_in = prod_ff;
            state_in = S_O_CMP;
         end
         S_O_CMP: begin
            // strictly closer only; ties keep the earlier hit
            if (tmp_ff < prod_ff) begin
               bd_in = d_ff; bm_in = m_ff; bo_in = o_ff;
               berr_in = err_ff; bden_in = den_ff;
            end
            adv_o = 1'b1;
         end
         S_F_NUM: state_in = S_F_LOAD;
         S_F_LOAD: begin
            num_in = prod_ff[NW-1:0];
            // sel 0: fin*M/(D*O), 1: fin*M/D, 2: fin/D
            case (sel_ff)
               2'd0: begin quo_in = prod_ff[NW-1:0]; dvs_in = bden_ff; end
               2'd1: begin quo_in = num_ff; dvs_in = QW'(bd_ff); end
               default: begin quo_in = NW'(fin_ff); dvs_in = QW'(bd_ff); end
            endcase
            if (sel_ff != 2'd0) begin
               num_in = num_ff;
            end
            rem_in = '0;
            cnt_in = 6'(NW);
            state_in = S_DIV;
         end
         S_DIV: begin
            if (cnt_ff == '0) begin
               case (sel_ff)
                  2'd0: ach_in = quo_ff[30:0];
                  2'd1: vco_in = quo_ff[30:0];
                  default: pfd_in = quo_ff[28:0];
               endcase
               if (sel_ff == 2'd2) begin
                  state_in = S_DONE;
               end else begin
                  sel_in = sel_ff + 2'd1;
                  state_in = S_F_LOAD;
               end
            end else begin
               rem_in = rem_ge ? QW'(rem_sh - {1'b0, dvs_ff}) : rem_sh[QW-1:0];
               quo_in = {quo_ff[NW-2:0], rem_ge};
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_DONE: begin
            valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // loop advance: O down, then M down, then D up
      if (adv_o) begin
         if (o_ff == DW'(1)) begin
            adv_m = 1'b1;
         end else begin
            o_in = o_ff - DW'(1);
            state_in = S_O_DEN;
         end
      end
      if (adv_m) begin
         if (m_ff == M_MIN) begin
            adv_d = 1'b1;
         end else begin
            m_in = m_ff - DW'(1);
            state_in = S_M_NUM;
         end
      end
      if (adv_d) begin
         if (d_ff == D_MAX) begin
            d_in = '0; m_in = '0; o_in = '0;
            sel_in = 2'd0;
            if (found_in) begin
               state_in = S_F_NUM;
            end else begin
               status_in = pll_ds_pkg::ST_NONE;
               state_in = S_DONE;
            end
         end else begin
            d_in = d_ff + DW'(1);
            state_in = S_D_LO;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         d_ff <= '0; m_ff <= '0; o_ff <= '0;
         bd_ff <= '0; bm_ff <= '0; bo_ff <= '0;
         berr_ff <= '0; found_ff <= 1'b0;
         status_ff <= pll_ds_pkg::ST_OK;
         sel_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         d_ff <= d_in; m_ff <= m_in; o_ff <= o_in;
         bd_ff <= bd_in; bm_ff <= bm_in; bo_ff <= bo_in;
         berr_ff <= berr_in; found_ff <= found_in;
         status_ff <= status_in;
         sel_ff <= sel_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      bden_ff <= bden_in;
      den_ff <= den_in;
      err_ff <= err_in;
      flag_ff <= flag_in;
      num_ff <= num_in;
      tmp_ff <= tmp_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      ach_ff <= ach_in;
      vco_ff <= vco_in;
      pfd_ff <= pfd_in;
   end

   // result word; every field but status is zero on an error
   logic ok;
   assign ok = status_ff == pll_ds_pkg::ST_OK;
   assign busy = state_ff != S_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_div_d = ok ? bd_ff : '0;
   assign rsp_div_m = ok ? bm_ff : '0;
   assign rsp_div_o = ok ? bo_ff : '0;
   assign rsp_word_divclk = !ok ? '0 : (bd_ff == DW'(1)) ? pll_ds_pkg::WORD_D_ONE :
                            pll_ds_pkg::hl_code({1'b0, bd_ff});
   assign rsp_word_feedback = !ok ? '0 :
                              pll_ds_pkg::WORD_BASE | pll_ds_pkg::hl_code({1'b0, bm_ff});
   assign rsp_word_out0 = !ok ? '0 : (bo_ff == DW'(1)) ? pll_ds_pkg::WORD_O_ONE :
                          pll_ds_pkg::WORD_BASE | pll_ds_pkg::hl_code({1'b0, bo_ff});
   assign rsp_word_out0_ext = (ok && bo_ff == DW'(1)) ? pll_ds_pkg::WORD_EXT_ONE : '0;
   assign rsp_word_out1 = !ok ? '0 :
                          pll_ds_pkg::WORD_BASE | pll_ds_pkg::hl_code({bo_ff, 1'b0});
   assign rsp_achieved_hz = ok ? ach_ff : '0;
   assign rsp_vco_hz = ok ? vco_ff : '0;
   assign rsp_pfd_hz = ok ? pfd_ff : '0;
endmodule

@@ bench/tb_pll_divider_search.sv @@
// Testbench for the PLL divider search: directed and random requests, checked
// against an exhaustive-search predictor. Depends on pll_ds_pkg and the RTL top.
`timescale 1ns / 1ps
module tb_pll_divider_search;

   // writes to this index must be ignored
   localparam logic [pll_ds_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam longint unsigned CYCLE_LIMIT = 64'd12000000;
   localparam int DRAIN_CYCLES = 200;
   localparam int HZ_W = pll_ds_pkg::HZ_W;
   localparam int DIV_W = pll_ds_pkg::DIV_W;
   localparam int WORD_W = pll_ds_pkg::WORD_W;
   localparam int IDX_W = pll_ds_pkg::IDX_W;

   typedef struct {
      logic [2:0]        status;
      logic [DIV_W-1:0]  div_d, div_m, div_o;
      logic [WORD_W-1:0] w_divclk, w_fb, w_out0, w_out0_ext, w_out1;
      logic [30:0]       achieved, vco;
      logic [28:0]       pfd;
   } pll_result_type;

   typedef struct {
      logic [HZ_W-1:0] hz;
      bit              hold;   // wait until every answer is back first
   } freq_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [HZ_W-1:0] req_requested_hz = '0;
   logic csr_wr_en = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [HZ_W-1:0] csr_wr_data = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic [DIV_W-1:0] rsp_div_d, rsp_div_m, rsp_div_o;
   logic [WORD_W-1:0] rsp_word_divclk, rsp_word_feedback, rsp_word_out0;
   logic [WORD_W-1:0] rsp_word_out0_ext, rsp_word_out1;
   logic [30:0] rsp_achieved_hz, rsp_vco_hz;
   logic [28:0] rsp_pfd_hz;

   // shadow copy of the three settings
   longint unsigned fin_hz  = 64'd100000000;
   longint unsigned omax_hz = 64'd750000000;
   longint unsigned tol_hz  = 64'd1000;

   freq_req_type    freq_queue[$];
   pll_result_type  pending_results[$];
   int              idle_pct = 0;
   int              fails = 0;
   int              words_in = 0;
   int              words_out = 0;
   int              locks = 0;
   int              no_lock = 0;
   int              rejects = 0;
   longint unsigned cycles = 0;

   pll_divider_search DUT (.*);

   always #10 clock = ~clock;

   function automatic logic [WORD_W-1:0] hilo_word(longint unsigned n);
      longint unsigned lo;
      longint unsigned hi;
      lo = n / 2;
      hi = n - lo;
      if (n <= 1) return '0;
      return WORD_W'((hi << 6) | lo);
   endfunction

   // Full search in the block's order: D rising, M falling, O falling.
   // Only a strictly smaller error (cross-multiplied) replaces the best.
   function automatic pll_result_type search_dividers(logic [HZ_W-1:0] req_hz);
      pll_result_type  r;
      longint unsigned req;
      longint unsigned num, den, tgt, err;
      longint unsigned bd, bm, bo, berr;
      bit              found;
      req = req_hz;
      r = '{default: '0};
      if (fin_hz < pll_ds_pkg::CLK_MIN_HZ || fin_hz > pll_ds_pkg::CLK_MAX_HZ) begin
         r.status = pll_ds_pkg::ST_CLK_RANGE;
         return r;
      end
      if (req == 0 || req > pll_ds_pkg::REQ_MAX_HZ) begin
         r.status = pll_ds_pkg::ST_REQ_RANGE;
         return r;
      end
      if (tol_hz == 0) begin
         r.status = pll_ds_pkg::ST_TOL_ZERO;
         return r;
      end
      found = 0;
      bd = 0; bm = 0; bo = 0; berr = 0;
      for (longint unsigned d = 1; d <= pll_ds_pkg::DEF_MAX_DIV_D; d++) begin
         if (fin_hz < pll_ds_pkg::PFD_MIN_HZ * d ||
             fin_hz > pll_ds_pkg::PFD_MAX_HZ * d) continue;
         for (longint unsigned m = pll_ds_pkg::DEF_MAX_DIV_MO;
              m >= pll_ds_pkg::DEF_MIN_DIV_M; m--) begin
            num = fin_hz * m;
            if (num < pll_ds_pkg::VCO_MIN_HZ * d ||
                num > pll_ds_pkg::VCO_MAX_HZ * d) continue;
            for (longint unsigned o = pll_ds_pkg::DEF_MAX_DIV_MO; o >= 1; o--) begin
               den = d * o;
               tgt = req * den;
               err = (num >= tgt) ? num - tgt : tgt - num;
               if (err > tol_hz * den) continue;
               if (num > omax_hz * den) continue;
               if (!found || err * (bd * bo) < berr * den) begin
                  found = 1;
                  bd = d; bm = m; bo = o;
                  berr = err & 64'hFFFF_FFFF_FFFF;
               end
            end
         end
      end
      if (!found) begin
         r.status = pll_ds_pkg::ST_NONE;
         return r;
      end
      r.status     = pll_ds_pkg::ST_OK;
      r.div_d      = DIV_W'(bd);
      r.div_m      = DIV_W'(bm);
      r.div_o      = DIV_W'(bo);
      r.w_divclk   = (bd == 1) ? pll_ds_pkg::WORD_D_ONE : hilo_word(bd);
      r.w_fb       = pll_ds_pkg::WORD_BASE | hilo_word(bm);
      r.w_out0     = (bo == 1) ? pll_ds_pkg::WORD_O_ONE :
                     (pll_ds_pkg::WORD_BASE | hilo_word(bo));
      r.w_out0_ext = (bo == 1) ? pll_ds_pkg::WORD_EXT_ONE : '0;
      r.w_out1     = pll_ds_pkg::WORD_BASE | hilo_word(2 * bo);
      r.achieved   = 31'((fin_hz * bm) / (bd * bo));
      r.vco        = 31'((fin_hz * bm) / bd);
      r.pfd        = 29'(fin_hz / bd);
      return r;
   endfunction

   // Driver: present the head of the queue, drop it once taken.
   always @(posedge clock) begin
      bit present;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            pending_results.push_back(search_dividers(req_requested_hz));
            freq_queue.pop_front();
            words_in++;
         end
         present = freq_queue.size() > 0 && $urandom_range(99) >= idle_pct;
         if (present && freq_queue[0].hold && pending_results.size() > 0) present = 0;
         start <= present;
         if (present) req_requested_hz <= freq_queue[0].hz;
      end
   end

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fails++;
      end
   endtask

   // Monitor: a result word lives for one cycle; compare against the oldest.
   always @(posedge clock) begin
      pll_result_type e;
      if (!reset && rsp_valid) begin
         words_out++;
         if (pending_results.size() == 0) begin
            $error("result word with nothing pending, status %0d", rsp_status);
            fails++;
         end else begin
            e = pending_results.pop_front();
            case (e.status)
               pll_ds_pkg::ST_OK:   locks++;
               pll_ds_pkg::ST_NONE: no_lock++;
               default: rejects++;
            endcase
            check_field("status", e.status, rsp_status);
            check_field("div_d", e.div_d, rsp_div_d);
            check_field("div_m", e.div_m, rsp_div_m);
            check_field("div_o", e.div_o, rsp_div_o);
            check_field("word_divclk", e.w_divclk, rsp_word_divclk);
            check_field("word_feedback", e.w_fb, rsp_word_feedback);
            check_field("word_out0", e.w_out0, rsp_word_out0);
            check_field("word_out0_ext", e.w_out0_ext, rsp_word_out0_ext);
            check_field("word_out1", e.w_out1, rsp_word_out1);
            check_field("achieved_hz", e.achieved, rsp_achieved_hz);
            check_field("vco_hz", e.vco, rsp_vco_hz);
            check_field("pfd_hz", e.pfd, rsp_pfd_hz);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [HZ_W-1:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      case (idx)
         pll_ds_pkg::REG_INPUT_CLOCK: fin_hz  = val;
         pll_ds_pkg::REG_OUTPUT_MAX:  omax_hz = val;
         pll_ds_pkg::REG_TOLERANCE:   tol_hz  = val[pll_ds_pkg::TOL_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (freq_queue.size() > 0 || pending_results.size() > 0 || start || busy);
      repeat (40) @(posedge clock);
   endtask

   task automatic push_req(logic [HZ_W-1:0] hz, bit hold = 0);
      freq_queue.push_back('{hz: hz, hold: hold});
   endtask

   // Request near fin*M/O so the search finds something; D is 1 at low clocks.
   task automatic push_lockable(bit hold);
      longint unsigned m, o, base;
      longint signed   off, hz;
      m = $urandom_range(pll_ds_pkg::DEF_MAX_DIV_MO, 48);
      o = $urandom_range(pll_ds_pkg::DEF_MAX_DIV_MO, 1);
      base = fin_hz * m / o;
      off = longint'($urandom_range(2 * (tol_hz % 20000))) - longint'(tol_hz % 20000);
      hz = longint'(base) + off;
      if (hz < 1) hz = 1;
      push_req(HZ_W'(hz), hold);
   endtask

   initial begin
      int sel;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      repeat (4) @(posedge clock);

      // Directed, reset settings (100 MHz in): request range edges, a few
      // real searches, top-bit request. Only three full searches here.
      push_req(30'd0);
      push_req(30'd750000001);
      push_req(30'h3FFF_FFFF);
      push_req(30'd100000000);
      push_req(30'd750000000);
      push_req(30'd123456789);
      wait_quiet();

      // Clock-range and zero-tolerance checks, and their priority order.
      write_reg(pll_ds_pkg::REG_INPUT_CLOCK, 30'd800000000);
      write_reg(pll_ds_pkg::REG_TOLERANCE, 30'h0800_0000);   // upper bits dropped -> zero
      push_req(30'd100000000);                   // tolerance zero
      push_req(30'd0);                           // request beats tolerance
      wait_quiet();
      write_reg(pll_ds_pkg::REG_INPUT_CLOCK, 30'd800000001);
      push_req(30'd0);                           // clock beats request
      wait_quiet();
      write_reg(pll_ds_pkg::REG_INPUT_CLOCK, 30'd9999999);
      push_req(30'd50000000);
      wait_quiet();
      write_reg(pll_ds_pkg::REG_INPUT_CLOCK, 30'd0);
      push_req(30'd1);
      wait_quiet();
      write_reg(pll_ds_pkg::REG_INPUT_CLOCK, 30'h3FFF_FFFF);
      push_req(30'd1);
      wait_quiet();

      // Lowest clock, widest tolerance, output cap at both ends.
      write_reg(pll_ds_pkg::REG_INPUT_CLOCK, 30'd10000000);
      write_reg(pll_ds_pkg::REG_TOLERANCE, 30'h3FFF_FFFF);
      write_reg(pll_ds_pkg::REG_OUTPUT_MAX, 30'h3FFF_FFFF);
      write_reg(REG_UNUSED, 30'd12345);
      push_req(30'd1);
      push_req(30'd640000000);
      wait_quiet();
      write_reg(pll_ds_pkg::REG_OUTPUT_MAX, 30'd0);          // nothing may be chosen
      push_req(30'd10000000);
      wait_quiet();
      write_reg(pll_ds_pkg::REG_TOLERANCE, 30'd1);
      write_reg(pll_ds_pkg::REG_OUTPUT_MAX, 30'd750000000);
      push_req(30'd10000000);
      push_req(30'd10000001);                    // no exact hit, but one within 1 Hz
      wait_quiet();

      // Random phases: no idling, sender idle 71%, receiver-side (no effect),
      // then both at 9%. Clocks stay low so D is always 1 and searches short.
      for (int ph = 0; ph < 4; ph++) begin
         wait_quiet();
         idle_pct = (ph == 1) ? 71 : (ph == 3) ? 9 : 0;
         write_reg(pll_ds_pkg::REG_INPUT_CLOCK,
                   HZ_W'($urandom_range(12000000, 10000000)));
         write_reg(pll_ds_pkg::REG_TOLERANCE, ($urandom_range(3) == 0) ?
                   HZ_W'($urandom_range(100000000, 1)) : HZ_W'($urandom_range(5000, 1)));
         write_reg(pll_ds_pkg::REG_OUTPUT_MAX, ($urandom_range(3) == 0) ?
                   HZ_W'($urandom) : HZ_W'($urandom_range(750000000, 100000000)));
         for (int k = 0; k < 25; k++) begin
            sel = $urandom_range(9);
            if (sel < 7) push_lockable(k == 12);
            else push_req(HZ_W'($urandom), k == 12);
         end
      end
      // one short burst with a bad clock: rejects only
      wait_quiet();
      idle_pct = 0;
      write_reg(pll_ds_pkg::REG_INPUT_CLOCK, ($urandom_range(1) == 0) ?
                HZ_W'($urandom_range(9999999, 0)) :
                HZ_W'($urandom_range(30'h3FFF_FFFF, 800000001)));
      for (int k = 0; k < 5; k++) push_req(HZ_W'($urandom));

      do @(posedge clock);
      while (freq_queue.size() > 0 || pending_results.size() > 0 || start);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests / %0d result words: %0d locked, %0d no match, %0d rejected",
               words_in, words_out, locks, no_lock, rejects);
      $display("Clock, request and tolerance range limits plus output cap extremes exercised");
      if (fails == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

@@ sim.f @@
rtl/pll_ds_pkg.sv
rtl/pll_divider_search.sv
bench/tb_pll_divider_search.sv
